// File: design/qtrs_pkg.sv
// ----------------------------------------------------------------------------
// qtrs_pkg: shared types and arithmetic for the quaternion TRS model matrix
// Beat payloads, pipeline stage records and the rotation entry helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package qtrs_pkg;

  localparam int QW    = 16;            // quaternion part, Q2.14
  localparam int SW    = 16;            // scale, Q8.8
  localparam int PW    = 32;            // position and matrix entry, Q16.16
  localparam int QPW   = 2 * QW;        // quaternion product, Q4.28
  localparam int ROTW  = QPW + 2;       // rotation entry, units of 2^-28
  localparam int MULW  = ROTW + SW;     // scaled entry, units of 2^-36
  localparam int FRAC_DROP = 20;
  localparam int QTW   = MULW - FRAC_DROP;

  localparam logic signed [ROTW-1:0] ONE_Q28  = ROTW'(1) <<< 28;
  localparam logic signed [MULW-1:0] ROUND_HALF = MULW'(1) <<< (FRAC_DROP - 1);

  typedef struct packed {
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [QW-1:0] quat_w;
    logic signed [SW-1:0] scale_x;
    logic signed [SW-1:0] scale_y;
    logic signed [SW-1:0] scale_z;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [PW-1:0] pos_z;
  } pose_t;

  typedef struct packed {
    logic signed [PW-1:0] m00;
    logic signed [PW-1:0] m01;
    logic signed [PW-1:0] m02;
    logic signed [PW-1:0] m03;
    logic signed [PW-1:0] m10;
    logic signed [PW-1:0] m11;
    logic signed [PW-1:0] m12;
    logic signed [PW-1:0] m13;
    logic signed [PW-1:0] m20;
    logic signed [PW-1:0] m21;
    logic signed [PW-1:0] m22;
    logic signed [PW-1:0] m23;
  } matrix_t;

  typedef struct packed {
    logic signed [QPW-1:0] xx;
    logic signed [QPW-1:0] yy;
    logic signed [QPW-1:0] zz;
    logic signed [QPW-1:0] xy;
    logic signed [QPW-1:0] xz;
    logic signed [QPW-1:0] yz;
    logic signed [QPW-1:0] xw;
    logic signed [QPW-1:0] yw;
    logic signed [QPW-1:0] zw;
    logic signed [SW-1:0]  scale_x;
    logic signed [SW-1:0]  scale_y;
    logic signed [SW-1:0]  scale_z;
    logic signed [PW-1:0]  pos_x;
    logic signed [PW-1:0]  pos_y;
    logic signed [PW-1:0]  pos_z;
  } prod_t;

  typedef struct packed {
    logic signed [ROTW-1:0] r00;
    logic signed [ROTW-1:0] r01;
    logic signed [ROTW-1:0] r02;
    logic signed [ROTW-1:0] r10;
    logic signed [ROTW-1:0] r11;
    logic signed [ROTW-1:0] r12;
    logic signed [ROTW-1:0] r20;
    logic signed [ROTW-1:0] r21;
    logic signed [ROTW-1:0] r22;
    logic signed [SW-1:0]   scale_x;
    logic signed [SW-1:0]   scale_y;
    logic signed [SW-1:0]   scale_z;
    logic signed [PW-1:0]   pos_x;
    logic signed [PW-1:0]   pos_y;
    logic signed [PW-1:0]   pos_z;
  } rot_t;

  function automatic logic signed [ROTW-1:0] rot_diag(logic signed [QPW-1:0] a,
                                                      logic signed [QPW-1:0] b);
    logic signed [ROTW-1:0] s;
    s = ROTW'(a) + ROTW'(b);
    return ONE_Q28 - (s <<< 1);
  endfunction

  function automatic logic signed [ROTW-1:0] rot_add(logic signed [QPW-1:0] a,
                                                     logic signed [QPW-1:0] b);
    logic signed [ROTW-1:0] s;
    s = ROTW'(a) + ROTW'(b);
    return s <<< 1;
  endfunction

  function automatic logic signed [ROTW-1:0] rot_sub(logic signed [QPW-1:0] a,
                                                     logic signed [QPW-1:0] b);
    logic signed [ROTW-1:0] s;
    s = ROTW'(a) - ROTW'(b);
    return s <<< 1;
  endfunction

endpackage

`default_nettype wire

// File: design/qtrs_pose_if.sv
// ----------------------------------------------------------------------------
// qtrs_pose_if: input channel of the model matrix block
// Valid/ready channel carrying one pose (quaternion, scale, position) a beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtrs_pose_if;
  logic            valid;
  logic            ready;
  qtrs_pkg::pose_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/qtrs_matrix_if.sv
// ----------------------------------------------------------------------------
// qtrs_matrix_if: output channel of the model matrix block
// Valid/ready channel carrying the top three matrix rows a beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtrs_matrix_if;
  logic              valid;
  logic              ready;
  qtrs_pkg::matrix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/qtrs_quat_prod.sv
// ----------------------------------------------------------------------------
// qtrs_quat_prod: quaternion product stage
// Registers the nine pairwise quaternion products, exact in Q4.28.
// ----------------------------------------------------------------------------
`default_nettype none

module qtrs_quat_prod (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire qtrs_pkg::pose_t pose,
  output qtrs_pkg::prod_t      prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod.xx      <= qtrs_pkg::QPW'(pose.quat_x) * qtrs_pkg::QPW'(pose.quat_x);
      prod.yy      <= qtrs_pkg::QPW'(pose.quat_y) * qtrs_pkg::QPW'(pose.quat_y);
      prod.zz      <= qtrs_pkg::QPW'(pose.quat_z) * qtrs_pkg::QPW'(pose.quat_z);
      prod.xy      <= qtrs_pkg::QPW'(pose.quat_x) * qtrs_pkg::QPW'(pose.quat_y);
      prod.xz      <= qtrs_pkg::QPW'(pose.quat_x) * qtrs_pkg::QPW'(pose.quat_z);
      prod.yz      <= qtrs_pkg::QPW'(pose.quat_y) * qtrs_pkg::QPW'(pose.quat_z);
      prod.xw      <= qtrs_pkg::QPW'(pose.quat_x) * qtrs_pkg::QPW'(pose.quat_w);
      prod.yw      <= qtrs_pkg::QPW'(pose.quat_y) * qtrs_pkg::QPW'(pose.quat_w);
      prod.zw      <= qtrs_pkg::QPW'(pose.quat_z) * qtrs_pkg::QPW'(pose.quat_w);
      prod.scale_x <= pose.scale_x;
      prod.scale_y <= pose.scale_y;
      prod.scale_z <= pose.scale_z;
      prod.pos_x   <= pose.pos_x;
      prod.pos_y   <= pose.pos_y;
      prod.pos_z   <= pose.pos_z;
    end
  end

endmodule

`default_nettype wire

// File: design/qtrs_rot_sum.sv
// ----------------------------------------------------------------------------
// qtrs_rot_sum: rotation matrix stage
// Combines the quaternion products into the nine rotation entries.
// ----------------------------------------------------------------------------
`default_nettype none

module qtrs_rot_sum (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire qtrs_pkg::prod_t prod,
  output qtrs_pkg::rot_t       rot
);

  always_ff @(posedge clk) begin
    if (en) begin
      rot.r00     <= qtrs_pkg::rot_diag(prod.yy, prod.zz);
      rot.r01     <= qtrs_pkg::rot_sub(prod.xy, prod.zw);
      rot.r02     <= qtrs_pkg::rot_add(prod.xz, prod.yw);
      rot.r10     <= qtrs_pkg::rot_add(prod.xy, prod.zw);
      rot.r11     <= qtrs_pkg::rot_diag(prod.xx, prod.zz);
      rot.r12     <= qtrs_pkg::rot_sub(prod.yz, prod.xw);
      rot.r20     <= qtrs_pkg::rot_sub(prod.xz, prod.yw);
      rot.r21     <= qtrs_pkg::rot_add(prod.yz, prod.xw);
      rot.r22     <= qtrs_pkg::rot_diag(prod.xx, prod.yy);
      rot.scale_x <= prod.scale_x;
      rot.scale_y <= prod.scale_y;
      rot.scale_z <= prod.scale_z;
      rot.pos_x   <= prod.pos_x;
      rot.pos_y   <= prod.pos_y;
      rot.pos_z   <= prod.pos_z;
    end
  end

endmodule

`default_nettype wire

// File: design/qtrs_scale_entry.sv
// ----------------------------------------------------------------------------
// qtrs_scale_entry: scaled matrix entry, two stages
// Multiplies a rotation entry by its axis scale, then rounds to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module qtrs_scale_entry (
  input  wire logic                                clk,
  input  wire logic                                en_mul,
  input  wire logic                                en_rnd,
  input  wire logic signed [qtrs_pkg::ROTW-1:0]    rot,
  input  wire logic signed [qtrs_pkg::SW-1:0]      scale,
  output logic signed [qtrs_pkg::PW-1:0]           entry
);

  logic signed [qtrs_pkg::MULW-1:0] prod;
  logic signed [qtrs_pkg::MULW-1:0] biased;
  logic signed [qtrs_pkg::QTW-1:0]  rounded;

  // Scaled entries stay well inside the Q16.16 range, so no clamp is applied.
  assign biased  = prod + qtrs_pkg::ROUND_HALF;
  assign rounded = biased[qtrs_pkg::MULW-1:qtrs_pkg::FRAC_DROP];

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod <= qtrs_pkg::MULW'(rot) * qtrs_pkg::MULW'(scale);
    end
    if (en_rnd) begin
      entry <= qtrs_pkg::PW'(rounded);
    end
  end

endmodule

`default_nettype wire

// File: design/quaternion_trs_model_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_trs_model_matrix: quaternion, scale and position to model matrix
// Four-stage pipeline that, unless stalled, takes one pose a cycle and
// returns the top three rows of the 4x4 model matrix: quaternion products,
// then rotation entries, then the multiply by the axis scale, then rounding
// to Q16.16 (round half up). The translation column is the position
// unchanged. It sustains one beat per clock while matrix ready is high; a
// stall on the matrix side holds only the stages that are full, so bubbles
// are squeezed out before pose ready drops. The quaternion is not normalized.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_trs_model_matrix (
  input  wire logic     clk,
  input  wire logic     rst,
  qtrs_pose_if.sink     pose,
  qtrs_matrix_if.source matrix
);

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  qtrs_pkg::prod_t prod;
  qtrs_pkg::rot_t  rot;

  logic signed [qtrs_pkg::PW-1:0] pos3_x, pos3_y, pos3_z;
  logic signed [qtrs_pkg::PW-1:0] pos4_x, pos4_y, pos4_z;

  assign adv4 = !v4 || matrix.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign pose.ready   = adv1;
  assign matrix.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= pose.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  qtrs_quat_prod u_prod (
    .clk  (clk),
    .en   (adv1),
    .pose (pose.data),
    .prod (prod)
  );

  qtrs_rot_sum u_rot (
    .clk  (clk),
    .en   (adv2),
    .prod (prod),
    .rot  (rot)
  );

  qtrs_scale_entry u_m00 (.clk(clk), .en_mul(adv3), .en_rnd(adv4),
                          .rot(rot.r00), .scale(rot.scale_x), .entry(matrix.data.m00));
  qtrs_scale_entry u_m01 (.clk(clk), .en_mul(adv3), .en_rnd(adv4),
                          .rot(rot.r01), .scale(rot.scale_y), .entry(matrix.data.m01));
  qtrs_scale_entry u_m02 (.clk(clk), .en_mul(adv3), .en_rnd(adv4),
                          .rot(rot.r02), .scale(rot.scale_z), .entry(matrix.data.m02));
  qtrs_scale_entry u_m10 (.clk(clk), .en_mul(adv3), .en_rnd(adv4),
                          .rot(rot.r10), .scale(rot.scale_x), .entry(matrix.data.m10));
  qtrs_scale_entry u_m11 (.clk(clk), .en_mul(adv3), .en_rnd(adv4),
                          .rot(rot.r11), .scale(rot.scale_y), .entry(matrix.data.m11));
  qtrs_scale_entry u_m12 (.clk(clk), .en_mul(adv3), .en_rnd(adv4),
                          .rot(rot.r12), .scale(rot.scale_z), .entry(matrix.data.m12));
  qtrs_scale_entry u_m20 (.clk(clk), .en_mul(adv3), .en_rnd(adv4),
                          .rot(rot.r20), .scale(rot.scale_x), .entry(matrix.data.m20));
  qtrs_scale_entry u_m21 (.clk(clk), .en_mul(adv3), .en_rnd(adv4),
                          .rot(rot.r21), .scale(rot.scale_y), .entry(matrix.data.m21));
  qtrs_scale_entry u_m22 (.clk(clk), .en_mul(adv3), .en_rnd(adv4),
                          .rot(rot.r22), .scale(rot.scale_z), .entry(matrix.data.m22));

  always_ff @(posedge clk) begin
    if (adv3) begin
      pos3_x <= rot.pos_x;
      pos3_y <= rot.pos_y;
      pos3_z <= rot.pos_z;
    end
    if (adv4) begin
      pos4_x <= pos3_x;
      pos4_y <= pos3_y;
      pos4_z <= pos3_z;
    end
  end

  assign matrix.data.m03 = pos4_x;
  assign matrix.data.m13 = pos4_y;
  assign matrix.data.m23 = pos4_z;

endmodule

`default_nettype wire
